// ===== src/frb_pkg.sv =====
// ---------------------------------------------------------------------------
// frb_pkg
// shared types and constants of the pcm frame ring buffer
// ---------------------------------------------------------------------------
package frb_pkg;

  localparam int DEF_SLOT_COUNT      = 1024;
  localparam int DEF_FRAME_BITS      = 32;
  localparam int DEF_MAX_READ        = 32;

  localparam int CFG_W   = 11;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 6;
  localparam int REQ_W   = 16;
  localparam int FILL_W  = 11;
  localparam int TOT_W   = 32;
  localparam int OP_W    = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int OQ_DEPTH = 4;
  localparam int QAW      = $clog2(OQ_DEPTH);
  localparam int QCW      = $clog2(OQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_out;
    logic              is_status;
    logic [REQ_W-1:0]  frames_requested;
    logic [REQ_W-1:0]  frames_done;
    logic [FILL_W-1:0] fill_level;
    logic              overflow;
    logic              underflow;
    logic [TOT_W-1:0]  overflow_total;
    logic [TOT_W-1:0]  underflow_total;
    logic              last;
  } res_t;

endpackage

// ===== src/frb_store.sv =====
// ---------------------------------------------------------------------------
// frb_store
// frame memory, one write port and one read port with registered data
// ---------------------------------------------------------------------------
module frb_store #(
  parameter int DEPTH = frb_pkg::DEF_SLOT_COUNT,
  parameter int WIDTH = frb_pkg::DEF_FRAME_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/frb_outq.sv =====
// ---------------------------------------------------------------------------
// frb_outq
// small result queue between the control logic and the output channel
// ---------------------------------------------------------------------------
module frb_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frb_pkg::res_t       push_item,
  input  logic                out_ready,
  output logic                out_valid,
  output frb_pkg::res_t       out_item,
  output logic [frb_pkg::QCW-1:0] count
);
  import frb_pkg::*;

  res_t           q_mem [OQ_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = q_mem[rp_r];
  assign count     = cnt_r;
  assign pop       = out_valid & out_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/pcm_frame_ring_buffer.sv =====
// ---------------------------------------------------------------------------
// pcm_frame_ring_buffer
// circular store of whole pcm frames with overflow and underflow accounting
// ---------------------------------------------------------------------------
// Requests enter on in_*: in_tuser selects write, read or clear, in_tlast
// closes a write request. A write frame is taken every cycle while the
// block is idle and the result queue is not full; the one that closes a
// request pushes a status result for out_*. A read request keeps in_tready
// low from when it is taken until its status result is queued: one frame
// leaves the memory read port per cycle while the result queue has room,
// each passes through the memory read register and the queue to out_*,
// and the status result (out_tlast high, out_tuser high) follows the last
// frame. A clear gives nothing back. Results pass through a four-entry
// queue, so a stalled receiver holds back frame reads and new requests
// only once that queue, counting a frame still in the memory read, is
// full. cfg_* writes the capacity in use; it empties the store and is
// always ready. Reset empties the store, zeroes the totals and sets the
// capacity to 1024 slots. Frame memory contents are not cleared.
// ---------------------------------------------------------------------------
module pcm_frame_ring_buffer #(
  parameter int SLOT_COUNT      = frb_pkg::DEF_SLOT_COUNT,
  parameter int FRAME_BITS      = frb_pkg::DEF_FRAME_BITS,
  parameter int MAX_READ        = frb_pkg::DEF_MAX_READ
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // frame_in [31:0], frame_count [37:32]
  input  logic [39:0]               in_tdata,
  // operation [1:0]
  input  logic [1:0]                in_tuser,
  input  logic                      in_tlast,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // frame_out [31:0], frames_requested [47:32], frames_done [63:48],
  // fill_level [74:64], overflow [75], underflow [76],
  // overflow_total [108:77], underflow_total [140:109]
  output logic [143:0]              out_tdata,
  // is_status [0]
  output logic                      out_tuser,
  output logic                      out_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [frb_pkg::CFG_W-1:0] cfg_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready
);
  import frb_pkg::*;

  localparam int SW  = (FRAME_BITS < DATA_W) ? FRAME_BITS : DATA_W;
  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int FW  = $clog2(SLOT_COUNT + 1);
  localparam int CW  = (FW > CFG_W) ? FW : CFG_W;
  localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_READ);

  function automatic logic [CW-1:0] cap_clamp(input logic [CFG_W-1:0] v);
    logic [CW-1:0] c;
    c = CW'(v);
    if (c == '0) begin
      c = CW'(1);
    end else if (c > CW'(SLOT_COUNT)) begin
      c = CW'(SLOT_COUNT);
    end
    return c;
  endfunction

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx = CW'(idx) + CW'(1);
    return (nx >= cap) ? '0 : IW'(nx);
  endfunction

  function automatic logic [REQ_W-1:0] inc_sat16(input logic [REQ_W-1:0] v);
    return (v == '1) ? v : v + REQ_W'(1);
  endfunction

  function automatic res_t make_status(input logic [REQ_W-1:0] req,
                                       input logic [REQ_W-1:0] done,
                                       input logic [CW-1:0]    fill,
                                       input logic             ovf,
                                       input logic             unf,
                                       input logic [TOT_W-1:0] ovt,
                                       input logic [TOT_W-1:0] unt);
    res_t s;
    s.frame_out        = '0;
    s.is_status        = 1'b1;
    s.frames_requested = req;
    s.frames_done      = done;
    s.fill_level       = FILL_W'(fill);
    s.overflow         = ovf;
    s.underflow        = unf;
    s.overflow_total   = ovt;
    s.underflow_total  = unt;
    s.last             = 1'b1;
    return s;
  endfunction

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cap_r, cap_nxt;
  logic [IW-1:0]      wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [TOT_W-1:0]   dropped_r, dropped_nxt;
  logic [TOT_W-1:0]   missed_r, missed_nxt;
  logic [REQ_W-1:0]   seen_r, seen_nxt;
  logic [REQ_W-1:0]   kept_r, kept_nxt;
  logic               drop_r, drop_nxt;
  logic [CNT_W-1:0]   want_r, want_nxt;
  logic [CNT_W-1:0]   got_r, got_nxt;
  logic               pend_r, pend_nxt;

  logic               in_acc, cfg_acc;
  op_t                op;
  logic [CNT_W-1:0]   req_cnt;
  logic               rd_more, rd_issue, rd_finish;
  logic [QCW-1:0]     q_cnt;
  logic [QCW:0]       q_occ;
  logic               mem_we;
  logic [SW-1:0]      mem_rdata;
  logic               q_push;
  res_t               q_item, out_item;
  logic [TOT_W:0]     missed_sum;

  assign op       = op_t'(in_tuser);
  assign req_cnt  = in_tdata[37:32];
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid & cfg_ready;
  assign in_tready = (state_r == ST_IDLE) && (q_cnt < QCW'(OQ_DEPTH));
  assign in_acc   = in_tvalid & in_tready;

  // interlock: no memory read is issued while a result slot is not reserved
  assign q_occ     = (QCW + 1)'(q_cnt) + (QCW + 1)'(pend_r);
  assign rd_more   = (got_r < want_r) && (fill_r != '0);
  assign rd_issue  = (state_r == ST_READ) && rd_more && (q_occ < (QCW + 1)'(OQ_DEPTH));
  assign rd_finish = (state_r == ST_READ) && !rd_more && !pend_r
                     && (q_cnt < QCW'(OQ_DEPTH));
  assign missed_sum = (TOT_W + 1)'(missed_r) + (TOT_W + 1)'(want_r - got_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op == OP_READ) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cap_nxt     = cap_r;
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    missed_nxt  = missed_r;
    seen_nxt    = seen_r;
    kept_nxt    = kept_r;
    drop_nxt    = drop_r;
    want_nxt    = want_r;
    got_nxt     = got_r;
    pend_nxt    = rd_issue;
    mem_we      = 1'b0;
    q_push      = 1'b0;
    q_item      = '0;

    if (in_acc) begin
      case (op)
        OP_WRITE: begin
          seen_nxt = inc_sat16(seen_r);
          if (fill_r < cap_r) begin
            mem_we     = 1'b1;
            wr_idx_nxt = idx_inc(wr_idx_r, cap_r);
            fill_nxt   = fill_r + CW'(1);
            kept_nxt   = inc_sat16(kept_r);
          end else begin
            dropped_nxt = (dropped_r == '1) ? dropped_r : dropped_r + TOT_W'(1);
            drop_nxt    = 1'b1;
          end
          if (in_tlast) begin
            q_push   = 1'b1;
            q_item   = make_status(seen_nxt, kept_nxt, fill_nxt, drop_nxt, 1'b0,
                                   dropped_nxt, missed_r);
            seen_nxt = '0;
            kept_nxt = '0;
            drop_nxt = 1'b0;
          end
        end
        OP_READ: begin
          want_nxt = (req_cnt > MAXR) ? MAXR : req_cnt;
          got_nxt  = '0;
        end
        OP_CLEAR: begin
          rd_idx_nxt = wr_idx_r;
          fill_nxt   = '0;
        end
        default: ;
      endcase
    end

    if (rd_issue) begin
      rd_idx_nxt = idx_inc(rd_idx_r, cap_r);
      fill_nxt   = fill_r - CW'(1);
      got_nxt    = got_r + CNT_W'(1);
    end

    if (pend_r) begin
      q_push           = 1'b1;
      q_item           = '0;
      q_item.frame_out = DATA_W'(mem_rdata);
    end

    if (rd_finish) begin
      missed_nxt = missed_sum[TOT_W] ? '1 : missed_sum[TOT_W-1:0];
      q_push     = 1'b1;
      q_item     = make_status(REQ_W'(want_r), REQ_W'(got_r), fill_r, 1'b0,
                               got_r < want_r, dropped_r, missed_nxt);
    end

    if (cfg_acc) begin
      cap_nxt    = cap_clamp(cfg_data);
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      fill_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_r     <= cap_clamp(CFG_RESET);
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      fill_r    <= '0;
      dropped_r <= '0;
      missed_r  <= '0;
      seen_r    <= '0;
      kept_r    <= '0;
      drop_r    <= 1'b0;
      want_r    <= '0;
      got_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cap_r     <= cap_nxt;
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
      missed_r  <= missed_nxt;
      seen_r    <= seen_nxt;
      kept_r    <= kept_nxt;
      drop_r    <= drop_nxt;
      want_r    <= want_nxt;
      got_r     <= got_nxt;
      pend_r    <= pend_nxt;
    end
  end

  frb_store #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (SW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_idx_r),
    .wr_data (SW'(in_tdata[31:0])),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rdata)
  );

  frb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item),
    .count     (q_cnt)
  );

  assign out_tdata = {3'b000,
                      out_item.underflow_total,
                      out_item.overflow_total,
                      out_item.underflow,
                      out_item.overflow,
                      out_item.fill_level,
                      out_item.frames_done,
                      out_item.frames_requested,
                      out_item.frame_out};
  assign out_tuser = out_item.is_status;
  assign out_tlast = out_item.last;

endmodule
